/* rtl/trgc_pkg.sv */
// package for the tile row group compressor
// shared packet type, queue sizing and stream code constants; no dependencies
`default_nettype none

package trgc_pkg;

    localparam int MAX_BYTES = 6;
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int POS_W     = $clog2(MAX_BYTES);

    localparam int Q_DEPTH   = 2;
    localparam int Q_IDX_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [4:0] REPEAT_LIMIT = 5'd31;
    localparam logic [7:0] GROUP_CODE   = 8'h20;
    localparam logic [7:0] END_MARK     = 8'h00;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;

    localparam logic [1:0] MC_SAME = 2'b00;
    localparam logic [1:0] MC_RAW  = 2'b01;
    localparam logic [1:0] MC_ZERO = 2'b10;
    localparam logic [1:0] MC_ONES = 2'b11;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [LEN_W-1:0]          len;
    } t_pkt;

endpackage

`default_nettype wire

/* rtl/trgc_front.sv */
// front end: accepts rows, keeps row/repeat state and pushes at most one packet per item
// depends on trgc_pkg
`default_nettype none

module trgc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_byte0,
    input  wire logic [7:0]       i_byte1,
    input  wire logic [7:0]       i_byte2,
    input  wire logic [7:0]       i_byte3,
    input  wire logic             i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output trgc_pkg::t_pkt        o_pkt
);
    import trgc_pkg::*;

    logic [31:0] r_prev, n_prev;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_seen, n_seen;

    logic [3:0][7:0] b;
    logic [3:0][7:0] raw;
    logic [7:0]      mask;
    logic [7:0]      last;
    logic            last_ok;
    logic [2:0]      nraw;
    logic [2:0]      diff;
    logic [3:0]      dmask;
    logic [3:0]      dbit;
    logic [4:0]      cnt1;
    logic [LEN_W-1:0] pos;
    t_pkt            pkt;
    logic            accept;

    assign b       = {i_byte3, i_byte2, i_byte1, i_byte0};
    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // mask form and raw byte list
    always_comb begin
        mask    = '0;
        raw     = '0;
        last    = '0;
        last_ok = 1'b0;
        nraw    = '0;
        for (int k = 0; k < 4; k++) begin
            if (b[k] == BYTE_ZERO) begin
                mask[7-2*k -: 2] = MC_ZERO;
            end else if (b[k] == BYTE_ONES) begin
                mask[7-2*k -: 2] = MC_ONES;
            end else if (!last_ok || b[k] != last) begin
                mask[7-2*k -: 2] = MC_RAW;
                last_ok          = 1'b1;
                last             = b[k];
                raw[nraw[1:0]]   = b[k];
                nraw             = nraw + 3'd1;
            end else begin
                mask[7-2*k -: 2] = MC_SAME;
            end
        end
    end

    // group-match differences against the previous row
    always_comb begin
        diff  = '0;
        dmask = '0;
        dbit  = '0;
        for (int k = 0; k < 4; k++) begin
            dbit[k] = (r_prev[8*k +: 8] != b[k]);
            if (dbit[k]) begin
                diff         = diff + 3'd1;
                dmask[3-k]   = 1'b1;
            end
        end
    end

    always_comb begin
        n_prev = r_prev;
        n_cnt  = r_cnt;
        n_seen = r_seen;
        pkt    = '0;
        pos    = '0;
        cnt1   = r_cnt + 5'd1;
        if (i_command) begin
            if (r_cnt != '0) begin
                pkt.data[pos[POS_W-1:0]] = {3'b000, r_cnt};
                pos = pos + LEN_W'(1);
            end
            pkt.data[pos[POS_W-1:0]] = END_MARK;
            pos    = pos + LEN_W'(1);
            n_prev = '0;
            n_cnt  = '0;
            n_seen = 1'b0;
        end else if (r_seen && b == r_prev) begin
            if (cnt1 == REPEAT_LIMIT) begin
                pkt.data[pos[POS_W-1:0]] = {3'b000, cnt1};
                pos   = pos + LEN_W'(1);
                n_cnt = '0;
            end else begin
                n_cnt = cnt1;
            end
        end else begin
            if (r_seen && r_cnt != '0) begin
                pkt.data[pos[POS_W-1:0]] = {3'b000, r_cnt};
                pos = pos + LEN_W'(1);
            end
            n_cnt  = '0;
            n_prev = b;
            n_seen = 1'b1;
            if (r_seen && nraw >= 3'd2 && diff < nraw) begin
                pkt.data[pos[POS_W-1:0]] = GROUP_CODE | {4'b0000, dmask};
                pos = pos + LEN_W'(1);
                for (int k = 0; k < 4; k++) begin
                    if (dbit[k]) begin
                        pkt.data[pos[POS_W-1:0]] = b[k];
                        pos = pos + LEN_W'(1);
                    end
                end
            end else begin
                pkt.data[pos[POS_W-1:0]] = mask;
                pos = pos + LEN_W'(1);
                for (int k = 0; k < 4; k++) begin
                    if (3'(k) < nraw) begin
                        pkt.data[pos[POS_W-1:0]] = raw[k];
                        pos = pos + LEN_W'(1);
                    end
                end
            end
        end
        pkt.len = pos;
    end

    assign o_pkt  = pkt;
    assign o_push = accept && (pos != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cnt  <= '0;
            r_seen <= 1'b0;
        end else if (accept) begin
            r_prev <= n_prev;
            r_cnt  <= n_cnt;
            r_seen <= n_seen;
        end
    end

    a_cnt_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < REPEAT_LIMIT)
        else $error("repeat count held at or above limit");

endmodule

`default_nettype wire

/* rtl/trgc_queue.sv */
// two-entry packet queue between front end and serializer
// depends on trgc_pkg
`default_nettype none

module trgc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  trgc_pkg::t_pkt     i_pkt,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output trgc_pkg::t_pkt     o_head
);
    import trgc_pkg::*;

    t_pkt               r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_IDX_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_IDX_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_nonempty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> !o_empty)
        else $error("queue empty after a push");

endmodule

`default_nettype wire

/* rtl/trgc_back.sv */
// serializer: sends the head packet one byte per beat and flags its last byte
// depends on trgc_pkg
`default_nettype none

module trgc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  trgc_pkg::t_pkt     i_head,
    input  wire logic          i_ready,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_pop
);
    import trgc_pkg::*;

    logic [LEN_W-1:0] r_idx;

    assign o_valid    = !i_empty;
    assign o_out_byte = i_head.data[r_idx[POS_W-1:0]];
    assign o_run_last = (r_idx == i_head.len - LEN_W'(1));
    assign o_pop      = o_valid && i_ready && o_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= o_run_last ? '0 : r_idx + LEN_W'(1);
        end
    end

    a_idx_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < i_head.len))
        else $error("byte index beyond packet length");

endmodule

`default_nettype wire

/* rtl/tile_row_group_compressor.sv */
// top level of the tile row group compressor: front end, packet queue, serializer
// depends on trgc_pkg, trgc_front, trgc_queue, trgc_back
//
//   channel | handshake         | payload
//   --------+-------------------+------------------------------------------
//   input   | i_valid/o_ready   | i_command, i_byte0..i_byte3
//   output  | o_valid/i_ready   | o_out_byte, o_run_last
//
// a row is taken whenever the queue has room; its 0..6 bytes leave
// one per beat while i_ready is high, up to 6 per row
// the single-byte output port limits throughput; rows with no output push nothing
// when the queue is empty, the first byte of a row is offered the cycle after the row is taken
// two packets fit in the queue, the one being sent included; input stalls when both are taken
// reset is synchronous, no clearing pass
`default_nettype none

module tile_row_group_compressor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_command,
    input  wire logic [7:0] i_byte0,
    input  wire logic [7:0] i_byte1,
    input  wire logic [7:0] i_byte2,
    input  wire logic [7:0] i_byte3,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);
    import trgc_pkg::*;

    logic full, empty, push, pop;
    t_pkt push_pkt, head_pkt;

    trgc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_byte0   (i_byte0),
        .i_byte1   (i_byte1),
        .i_byte2   (i_byte2),
        .i_byte3   (i_byte3),
        .i_full    (full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_pkt     (push_pkt)
    );

    trgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_pkt)
    );

    trgc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head_pkt),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_pop      (pop)
    );

endmodule

`default_nettype wire

/* sim/tb_tile_row_group_compressor.sv */
// testbench for tile_row_group_compressor: directed table then random rows,
// every output beat checked against an in-bench row coder or the table's expected bytes
// depends on trgc_pkg and rtl/tile_row_group_compressor.sv
`default_nettype none

module tb_tile_row_group_compressor;
    timeunit 1ns;
    timeprecision 1ps;

    import trgc_pkg::*;

    localparam logic CMD_ROW    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;
    localparam int   N_RANDOM   = 300;
    localparam int   LONG_HOLD  = 300;
    localparam int   WATCHDOG   = 3000;

    typedef struct packed {
        logic        typed;
        logic [2:0]  n;
        logic [47:0] e;
    } t_plan;

    typedef struct packed {
        logic       cmd;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [5:0] reps;
        t_plan      plan;
    } t_dir;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_coded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_command = 1'b0;
    logic [7:0] i_byte0 = 8'h00;
    logic [7:0] i_byte1 = 8'h00;
    logic [7:0] i_byte2 = 8'h00;
    logic [7:0] i_byte3 = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    tile_row_group_compressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_byte0    (i_byte0),
        .i_byte1    (i_byte1),
        .i_byte2    (i_byte2),
        .i_byte3    (i_byte3),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // coder state
    logic [31:0] prev_row = '0;
    logic [4:0]  rep_cnt = '0;
    logic        have_row = 1'b0;

    t_coded pending_bytes[$];
    t_plan  typed_plan[$];
    t_dir   dir_rows[$];
    int     errors = 0;
    int     rows_in = 0;
    int     items_sent = 0;
    int     burst_left = 0;
    int     idle_cycles = 0;
    bit     held = 1'b0;

    task automatic code_row(input logic cmd, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            output logic [5:0][7:0] ob, output int n);
        logic [3:0][7:0] b;
        logic [3:0][7:0] raw;
        logic [31:0]     row;
        logic [7:0]      mask;
        logic [7:0]      last_raw;
        logic [3:0]      dmask;
        logic            last_ok;
        int              nraw;
        int              ndiff;
        ob = '0;
        n = 0;
        if (cmd == CMD_FINISH) begin
            if (rep_cnt != 0) begin
                ob[n] = {3'b000, rep_cnt};
                n++;
            end
            ob[n] = END_MARK;
            n++;
            prev_row = '0;
            rep_cnt = '0;
            have_row = 1'b0;
            return;
        end
        b = {b3, b2, b1, b0};
        row = {b3, b2, b1, b0};
        if (have_row) begin
            if (row == prev_row) begin
                rep_cnt = rep_cnt + 5'd1;
                if (rep_cnt == REPEAT_LIMIT) begin
                    ob[n] = {3'b000, rep_cnt};
                    n++;
                    rep_cnt = '0;
                end
                return;
            end
            if (rep_cnt != 0) begin
                ob[n] = {3'b000, rep_cnt};
                n++;
                rep_cnt = '0;
            end
        end
        mask = '0;
        raw = '0;
        nraw = 0;
        last_ok = 1'b0;
        last_raw = '0;
        for (int k = 0; k < 4; k++) begin
            if (b[k] == BYTE_ZERO) begin
                mask[7-2*k -: 2] = MC_ZERO;
            end else if (b[k] == BYTE_ONES) begin
                mask[7-2*k -: 2] = MC_ONES;
            end else if (!last_ok || b[k] != last_raw) begin
                mask[7-2*k -: 2] = MC_RAW;
                last_ok = 1'b1;
                last_raw = b[k];
                raw[nraw] = b[k];
                nraw++;
            end else begin
                mask[7-2*k -: 2] = MC_SAME;
            end
        end
        if (have_row && nraw >= 2) begin
            ndiff = 0;
            dmask = '0;
            for (int k = 0; k < 4; k++) begin
                if (prev_row[8*k +: 8] != b[k]) begin
                    ndiff++;
                    dmask[3-k] = 1'b1;
                end
            end
            if (ndiff < nraw) begin
                ob[n] = GROUP_CODE | {4'b0000, dmask};
                n++;
                for (int k = 0; k < 4; k++) begin
                    if (prev_row[8*k +: 8] != b[k]) begin
                        ob[n] = b[k];
                        n++;
                    end
                end
                prev_row = row;
                return;
            end
        end
        prev_row = row;
        have_row = 1'b1;
        ob[n] = mask;
        n++;
        for (int k = 0; k < nraw; k++) begin
            ob[n] = raw[k];
            n++;
        end
    endtask

    // input and output beats, input handled first at each edge
    always @(posedge i_clk) begin
        logic [5:0][7:0] ob;
        int              n;
        t_plan           p;
        t_coded          c;
        t_coded          got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                code_row(i_command, i_byte0, i_byte1, i_byte2, i_byte3, ob, n);
                p = typed_plan.pop_front();
                rows_in++;
                if (p.typed) begin
                    n = int'(p.n);
                    for (int j = 0; j < 6; j++) ob[j] = p.e[47-8*j -: 8];
                end
                for (int j = 0; j < n; j++) begin
                    c.data = ob[j];
                    c.last = (j == n - 1);
                    pending_bytes.push_back(c);
                end
            end
            if (o_valid && i_ready) begin
                got.data = o_out_byte;
                got.last = o_run_last;
                if (pending_bytes.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                             $time, got.data, got.last);
                    errors++;
                end else begin
                    c = pending_bytes.pop_front();
                    if (got.data !== c.data) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, c.data, got.data);
                        errors++;
                    end
                    if (got.last !== c.last) begin
                        $display("%0t: run_last mismatch, expected %0b, actual %0b",
                                 $time, c.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG) begin
                    $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off so the block fills up
    initial begin
        int mode;
        int len;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && rows_in >= 100) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                len = $urandom_range(5, 60);
                repeat (len) begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        default: i_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3, input t_plan p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        typed_plan.push_back(p);
        i_valid <= 1'b1;
        i_command <= cmd;
        i_byte0 <= b0;
        i_byte1 <= b1;
        i_byte2 <= b2;
        i_byte3 <= b3;
        items_sent++;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_bytes.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic dir_row(input logic cmd, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3, input int reps,
                           input int n, input logic [47:0] e);
        t_dir d;
        d.cmd = cmd;
        d.b0 = b0;
        d.b1 = b1;
        d.b2 = b2;
        d.b3 = b3;
        d.reps = 6'(reps);
        d.plan.typed = (n >= 0);
        d.plan.n = (n >= 0) ? 3'(n) : 3'd0;
        d.plan.e = e;
        dir_rows.push_back(d);
    endtask

    function automatic logic [7:0] pick_byte(input logic [7:0] old, input logic [7:0] recent);
        case ($urandom_range(0, 9))
            0, 1: return BYTE_ZERO;
            2, 3: return BYTE_ONES;
            4, 5, 6: return old;
            7: return recent;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        t_dir        d;
        t_plan       free;
        logic [31:0] last_row;
        logic [7:0]  nb0;
        logic [7:0]  nb1;
        logic [7:0]  nb2;
        logic [7:0]  nb3;
        int          sel;
        int          run;
        int          start;
        bit          paused;

        free = '0;
        paused = 1'b0;
        last_row = '0;

        // empty finish, first rows, repeats, max-length row, group form, count of 31
        dir_row(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 48'h00_00_00_00_00_00);
        dir_row(CMD_ROW,    8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 48'hAA_00_00_00_00_00);
        dir_row(CMD_ROW,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 48'hFF_00_00_00_00_00);
        dir_row(CMD_ROW,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 48'h0);
        dir_row(CMD_ROW,    8'h12, 8'h34, 8'h56, 8'h78, 1, 6, 48'h01_55_12_34_56_78);
        dir_row(CMD_ROW,    8'h12, 8'h34, 8'h56, 8'h79, 1, 2, 48'h21_79_00_00_00_00);
        dir_row(CMD_ROW,    8'h11, 8'h11, 8'h11, 8'h11, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'h00, 8'hFF, 8'h33, 8'h33, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'h33, 8'h00, 8'h33, 8'h44, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'h33, 8'h00, 8'h55, 8'h66, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'h33, 8'h00, 8'h55, 8'h66, 30, -1, 48'h0);
        dir_row(CMD_ROW,    8'h33, 8'h00, 8'h55, 8'h66, 1, 1, 48'h1F_00_00_00_00_00);
        dir_row(CMD_ROW,    8'h33, 8'h00, 8'h55, 8'h66, 1, -1, 48'h0);
        dir_row(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 1, 2, 48'h01_00_00_00_00_00);
        dir_row(CMD_ROW,    8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 48'hAA_00_00_00_00_00);
        dir_row(CMD_ROW,    8'h00, 8'h00, 8'h00, 8'h00, 2, -1, 48'h0);
        dir_row(CMD_ROW,    8'h80, 8'h7F, 8'h01, 8'hFE, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'h80, 8'h80, 8'h80, 8'h80, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'hAA, 8'hBB, 8'hAA, 8'hBB, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'hAA, 8'hBB, 8'hAA, 8'hCC, 1, -1, 48'h0);
        dir_row(CMD_ROW,    8'h01, 8'hBB, 8'hAA, 8'hCC, 1, -1, 48'h0);
        dir_row(CMD_FINISH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 48'h00_00_00_00_00_00);
        dir_row(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 48'h00_00_00_00_00_00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            d = dir_rows[i];
            repeat (d.reps) send_beat(d.cmd, d.b0, d.b1, d.b2, d.b3, d.plan);
        end
        wait_drained();

        start = items_sent;
        while (items_sent - start < N_RANDOM) begin
            if (!paused && items_sent - start >= N_RANDOM / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                send_beat(CMD_FINISH, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), free);
            end else if (sel < 14) begin
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 40)
                                                  : $urandom_range(1, 6);
                repeat (run) send_beat(CMD_ROW, last_row[7:0], last_row[15:8],
                                       last_row[23:16], last_row[31:24], free);
            end else begin
                if (sel < 18) begin
                    {nb3, nb2, nb1, nb0} = $urandom;
                end else begin
                    nb0 = pick_byte(last_row[7:0], last_row[31:24]);
                    nb1 = pick_byte(last_row[15:8], nb0);
                    nb2 = pick_byte(last_row[23:16], nb1);
                    nb3 = pick_byte(last_row[31:24], nb2);
                end
                last_row = {nb3, nb2, nb1, nb0};
                send_beat(CMD_ROW, nb0, nb1, nb2, nb3, free);
            end
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        if (pending_bytes.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending_bytes.size());
            errors++;
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
